/* rtl/camera_ray_direction_generator_assert.svh */
// Assertion macros for the camera ray direction generator checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef CAMERA_RAY_DIRECTION_GENERATOR_ASSERT_SVH
`define CAMERA_RAY_DIRECTION_GENERATOR_ASSERT_SVH

// Same-cycle implication, off during reset
`define CRDG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define CRDG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Holds in the cycle after a reset edge
`define CRDG_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

/* rtl/crdg_pkg.sv */
// Shared constants, types and helpers for the camera ray direction generator.
// No dependencies; used by every RTL module of the block.
package crdg_pkg;

  localparam int PIXEL_COORD_BITS = 12;
  localparam int DIR_FRAC_BITS    = 16;

  localparam int NUM_AXES   = 3;
  localparam int COORD_BITS = 21;
  localparam int REG_BITS   = NUM_AXES * COORD_BITS;
  localparam int CFG_IDX_BITS = 2;

  // Plane vector: pixel (zero-extended, signed) times coordinate
  localparam int PROD_BITS = PIXEL_COORD_BITS + 1 + COORD_BITS;
  localparam int VEC_BITS  = PROD_BITS + 1;
  localparam int MAG_BITS  = VEC_BITS - 1;
  localparam int NORM_MSB  = COORD_BITS - 1;
  localparam int SHIFT_BITS = $clog2(MAG_BITS);

  // Square root of (sum of squares << RAD_SHIFT)
  localparam int SQ_BITS   = 2 * COORD_BITS + 2;
  localparam int RAD_SHIFT = 20;
  localparam int RAD_BITS  = SQ_BITS + RAD_SHIFT;
  localparam int SQ_STEPS  = RAD_BITS / 2;
  localparam int ROOT_BITS = SQ_STEPS;
  localparam int REM_BITS  = ROOT_BITS + 2;

  // Division (|a| << DIV_SHIFT + root/2) / root
  localparam int DIV_SHIFT = DIR_FRAC_BITS + 10;
  localparam int DIV_STEPS = DIR_FRAC_BITS + 1;
  localparam int DIVD_BITS = COORD_BITS + DIV_SHIFT + 1;

  localparam int OUT_BITS = DIR_FRAC_BITS + 2;
  localparam int DIR_ONE  = 1 << DIR_FRAC_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CORNER = 2'd0,
    CFG_COLUMN = 2'd1,
    CFG_ROW    = 2'd2
  } cfg_idx_t;

  // Normalized components and flags that ride along the root and divide pipes
  typedef struct packed {
    logic [NUM_AXES-1:0][COORD_BITS-1:0] a;
    logic [NUM_AXES-1:0]                 neg;
    logic                                zero;
  } side_t;

  function automatic logic signed [COORD_BITS-1:0] coord_of(
    input logic [REG_BITS-1:0] r,
    input int                  axis
  );
    return r[axis*COORD_BITS +: COORD_BITS];
  endfunction

endpackage

/* rtl/crdg_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
// Depends on crdg_pkg.
module crdg_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [crdg_pkg::SQ_BITS-1:0] in_sum,
  input  crdg_pkg::side_t              in_side,
  output logic                         out_valid,
  output logic [crdg_pkg::ROOT_BITS-1:0] out_root,
  output crdg_pkg::side_t              out_side
);
  import crdg_pkg::*;

  logic [SQ_STEPS-1:0]  vld_r;
  logic [REM_BITS-1:0]  rem_r   [SQ_STEPS];
  logic [REM_BITS-1:0]  rem_nxt [SQ_STEPS];
  logic [ROOT_BITS-1:0] root_r   [SQ_STEPS];
  logic [ROOT_BITS-1:0] root_nxt [SQ_STEPS];
  logic [RAD_BITS-1:0]  rad_r   [SQ_STEPS];
  logic [RAD_BITS-1:0]  rad_nxt [SQ_STEPS];
  side_t                side_r   [SQ_STEPS];
  side_t                side_nxt [SQ_STEPS];

  // One restoring step per stage; radicand shifts out two bits at a time
  always_comb begin
    logic [REM_BITS-1:0]  rem_s;
    logic [ROOT_BITS-1:0] root_s;
    logic [RAD_BITS-1:0]  rad_s;
    logic [REM_BITS+1:0]  trial;
    logic [REM_BITS+1:0]  cand;
    logic                 ge;
    for (int k = 0; k < SQ_STEPS; k++) begin
      if (k == 0) begin
        rem_s       = '0;
        root_s      = '0;
        rad_s       = {in_sum, {RAD_SHIFT{1'b0}}};
        side_nxt[k] = in_side;
      end else begin
        rem_s       = rem_r[k-1];
        root_s      = root_r[k-1];
        rad_s       = rad_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      trial = {rem_s, rad_s[RAD_BITS-1 -: 2]};
      cand  = {2'b00, root_s, 2'b01};
      ge    = (trial >= cand);
      rem_nxt[k]  = ge ? REM_BITS'(trial - cand) : REM_BITS'(trial);
      root_nxt[k] = {root_s[ROOT_BITS-2:0], ge};
      rad_nxt[k]  = {rad_s[RAD_BITS-3:0], 2'b00};
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQ_STEPS-2:0], in_valid};
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_STEPS; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= rad_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign out_valid = vld_r[SQ_STEPS-1];
  assign out_root  = root_r[SQ_STEPS-1];
  assign out_side  = side_r[SQ_STEPS-1];

endmodule

/* rtl/crdg_div.sv */
// Pipelined rounding divider for the three axes, one quotient bit per stage.
// Depends on crdg_pkg.
module crdg_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [crdg_pkg::ROOT_BITS-1:0] in_root,
  input  crdg_pkg::side_t                in_side,
  output logic                           out_valid,
  output logic [crdg_pkg::NUM_AXES-1:0][crdg_pkg::DIV_STEPS-1:0] out_quo,
  output crdg_pkg::side_t                out_side
);
  import crdg_pkg::*;

  // Front stage: dividend with half the divisor added for rounding
  logic                 pre_vld_r;
  logic [ROOT_BITS-1:0] pre_root_r;
  logic [DIVD_BITS-1:0] pre_dvd_r [NUM_AXES];
  side_t                pre_side_r;

  logic [DIV_STEPS-1:0] vld_r;
  logic [ROOT_BITS-1:0] den_r    [DIV_STEPS];
  logic [ROOT_BITS-1:0] den_nxt  [DIV_STEPS];
  side_t                side_r   [DIV_STEPS];
  side_t                side_nxt [DIV_STEPS];
  logic [ROOT_BITS-1:0] rem_r    [DIV_STEPS][NUM_AXES];
  logic [ROOT_BITS-1:0] rem_nxt  [DIV_STEPS][NUM_AXES];
  logic [DIV_STEPS-1:0] low_r    [DIV_STEPS][NUM_AXES];
  logic [DIV_STEPS-1:0] low_nxt  [DIV_STEPS][NUM_AXES];
  logic [DIV_STEPS-1:0] quo_r    [DIV_STEPS][NUM_AXES];
  logic [DIV_STEPS-1:0] quo_nxt  [DIV_STEPS][NUM_AXES];

  always_ff @(posedge clk) begin
    if (en) begin
      pre_root_r <= in_root;
      pre_side_r <= in_side;
      for (int i = 0; i < NUM_AXES; i++) begin
        pre_dvd_r[i] <= DIVD_BITS'({in_side.a[i], {DIV_SHIFT{1'b0}}})
                      + DIVD_BITS'(in_root >> 1);
      end
    end
  end

  // Restoring steps; the top dividend bits are below the divisor already
  always_comb begin
    logic [ROOT_BITS-1:0] rem_s;
    logic [DIV_STEPS-1:0] low_s;
    logic [DIV_STEPS-1:0] quo_s;
    logic [ROOT_BITS-1:0] den_s;
    logic [ROOT_BITS:0]   t;
    logic                 ge;
    for (int k = 0; k < DIV_STEPS; k++) begin
      den_s = (k == 0) ? pre_root_r : den_r[k-1];
      den_nxt[k]  = den_s;
      side_nxt[k] = (k == 0) ? pre_side_r : side_r[k-1];
      for (int i = 0; i < NUM_AXES; i++) begin
        if (k == 0) begin
          rem_s = ROOT_BITS'(pre_dvd_r[i][DIVD_BITS-1:DIV_STEPS]);
          low_s = pre_dvd_r[i][DIV_STEPS-1:0];
          quo_s = '0;
        end else begin
          rem_s = rem_r[k-1][i];
          low_s = low_r[k-1][i];
          quo_s = quo_r[k-1][i];
        end
        t  = {rem_s, low_s[DIV_STEPS-1]};
        ge = (t >= {1'b0, den_s});
        rem_nxt[k][i] = ge ? ROOT_BITS'(t - {1'b0, den_s}) : ROOT_BITS'(t);
        low_nxt[k][i] = {low_s[DIV_STEPS-2:0], 1'b0};
        quo_nxt[k][i] = {quo_s[DIV_STEPS-2:0], ge};
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
      vld_r     <= '0;
    end else if (en) begin
      pre_vld_r <= in_valid;
      vld_r     <= {vld_r[DIV_STEPS-2:0], pre_vld_r};
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        den_r[k]  <= den_nxt[k];
        side_r[k] <= side_nxt[k];
        for (int i = 0; i < NUM_AXES; i++) begin
          rem_r[k][i] <= rem_nxt[k][i];
          low_r[k][i] <= low_nxt[k][i];
          quo_r[k][i] <= quo_nxt[k][i];
        end
      end
    end
  end

  assign out_valid = vld_r[DIV_STEPS-1];
  assign out_side  = side_r[DIV_STEPS-1];
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      out_quo[i] = quo_r[DIV_STEPS-1][i];
    end
  end

endmodule

/* rtl/camera_ray_direction_generator.sv */
// Top level of the camera ray direction generator: pixel to unit ray direction.
// Depends on crdg_pkg, crdg_sqrt and crdg_div.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------------------
//   in      | in_valid / in_stall | in_pixel_x, in_pixel_y
//   out     | out_valid/out_stall | out_dir_x/y/z, out_degenerate
//   cfg     | cfg_wr_en           | cfg_index, cfg_data
//
// One item per cycle while the pipe is not held; an accepted item passes through
// 7 front stages, 32 root stages, 18 divide stages and the output register.
// Reset clears the valid bits and the three plane vectors.
// The pipe moves as one; it holds only when the output register is full and
// stalled while a finished item waits in the last divide stage.
module camera_ray_direction_generator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [crdg_pkg::PIXEL_COORD_BITS-1:0] in_pixel_x,
  input  logic [crdg_pkg::PIXEL_COORD_BITS-1:0] in_pixel_y,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [crdg_pkg::OUT_BITS-1:0]  out_dir_x,
  output logic signed [crdg_pkg::OUT_BITS-1:0]  out_dir_y,
  output logic signed [crdg_pkg::OUT_BITS-1:0]  out_dir_z,
  output logic                                  out_degenerate,
  input  logic                                  cfg_wr_en,
  input  logic [crdg_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [crdg_pkg::REG_BITS-1:0]         cfg_data
);
  import crdg_pkg::*;

  logic [REG_BITS-1:0] corner_r, column_r, row_r;

  logic adv;
  logic [6:0] vld_r;

  // Stage 1: products
  logic signed [COORD_BITS-1:0] cor1_r [NUM_AXES];
  logic signed [PROD_BITS-1:0]  pc1_r  [NUM_AXES];
  logic signed [PROD_BITS-1:0]  pr1_r  [NUM_AXES];
  // Stage 2: sign and magnitude
  logic [MAG_BITS-1:0] mag2_r [NUM_AXES];
  logic [NUM_AXES-1:0] neg2_r;
  // Stage 3: largest magnitude
  logic [MAG_BITS-1:0] mag3_r [NUM_AXES];
  logic [NUM_AXES-1:0] neg3_r;
  logic [MAG_BITS-1:0] max3_r;
  // Stage 4: shift amount
  logic [MAG_BITS-1:0]   mag4_r [NUM_AXES];
  logic [NUM_AXES-1:0]   neg4_r;
  logic                  zero4_r;
  logic                  lsh4_r;
  logic [SHIFT_BITS-1:0] amt4_r;
  // Stage 5..7: normalized, squared, summed
  side_t                      side5_r, side6_r, side7_r;
  logic [2*COORD_BITS-1:0]    sq6_r [NUM_AXES];
  logic [SQ_BITS-1:0]         sum7_r;

  logic            sq_vld;
  logic [ROOT_BITS-1:0] sq_root;
  side_t           sq_side;
  logic            dv_vld;
  logic [NUM_AXES-1:0][DIV_STEPS-1:0] dv_quo;
  side_t           dv_side;

  logic                out_vld_r;
  logic [OUT_BITS-1:0] dir_r   [NUM_AXES];
  logic [OUT_BITS-1:0] dir_nxt [NUM_AXES];
  logic                deg_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_r <= '0;
      column_r <= '0;
      row_r    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_CORNER: corner_r <= cfg_data;
        CFG_COLUMN: column_r <= cfg_data;
        CFG_ROW:    row_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: hold only when a finished item cannot leave
  assign adv      = !(out_vld_r && out_stall && dv_vld);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[5:0], in_valid};
    end
  end

  // Stage 1: pixel times step vectors
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        cor1_r[i] <= coord_of(corner_r, i);
        pc1_r[i]  <= $signed({1'b0, in_pixel_x}) * coord_of(column_r, i);
        pr1_r[i]  <= $signed({1'b0, in_pixel_y}) * coord_of(row_r, i);
      end
    end
  end

  // Stage 2: plane vector, split to sign and magnitude
  always_ff @(posedge clk) begin
    logic signed [VEC_BITS-1:0] v;
    if (adv) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        v = VEC_BITS'(cor1_r[i]) + VEC_BITS'(pc1_r[i]) - VEC_BITS'(pr1_r[i]);
        neg2_r[i] <= v[VEC_BITS-1];
        mag2_r[i] <= v[VEC_BITS-1] ? MAG_BITS'(-v) : MAG_BITS'(v);
      end
    end
  end

  // Stage 3: largest magnitude
  always_ff @(posedge clk) begin
    logic [MAG_BITS-1:0] m;
    if (adv) begin
      m = (mag2_r[0] > mag2_r[1]) ? mag2_r[0] : mag2_r[1];
      max3_r <= (mag2_r[2] > m) ? mag2_r[2] : m;
      neg3_r <= neg2_r;
      for (int i = 0; i < NUM_AXES; i++) begin
        mag3_r[i] <= mag2_r[i];
      end
    end
  end

  // Stage 4: leading one of the maximum gives the shift to [2^20, 2^21)
  always_ff @(posedge clk) begin
    logic [SHIFT_BITS-1:0] pos;
    if (adv) begin
      pos = '0;
      for (int b = 0; b < MAG_BITS; b++) begin
        if (max3_r[b]) begin
          pos = SHIFT_BITS'(b);
        end
      end
      zero4_r <= (max3_r == '0);
      if (pos >= SHIFT_BITS'(NORM_MSB)) begin
        lsh4_r <= 1'b0;
        amt4_r <= pos - SHIFT_BITS'(NORM_MSB);
      end else begin
        lsh4_r <= 1'b1;
        amt4_r <= SHIFT_BITS'(NORM_MSB) - pos;
      end
      neg4_r <= neg3_r;
      for (int i = 0; i < NUM_AXES; i++) begin
        mag4_r[i] <= mag3_r[i];
      end
    end
  end

  // Stage 5: apply the shift
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        side5_r.a[i] <= lsh4_r ? COORD_BITS'(mag4_r[i] << amt4_r)
                               : COORD_BITS'(mag4_r[i] >> amt4_r);
      end
      side5_r.neg  <= neg4_r;
      side5_r.zero <= zero4_r;
    end
  end

  // Stage 6: squares
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        sq6_r[i] <= side5_r.a[i] * side5_r.a[i];
      end
      side6_r <= side5_r;
    end
  end

  // Stage 7: sum of squares
  always_ff @(posedge clk) begin
    if (adv) begin
      sum7_r  <= SQ_BITS'(sq6_r[0]) + SQ_BITS'(sq6_r[1]) + SQ_BITS'(sq6_r[2]);
      side7_r <= side6_r;
    end
  end

  crdg_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (vld_r[6]),
    .in_sum    (sum7_r),
    .in_side   (side7_r),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  crdg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (sq_vld),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_vld),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // Cap, sign and the zero-vector case
  always_comb begin
    logic [DIV_STEPS-1:0] q;
    logic [OUT_BITS-1:0]  m;
    for (int i = 0; i < NUM_AXES; i++) begin
      q = (dv_quo[i] > DIV_STEPS'(DIR_ONE)) ? DIV_STEPS'(DIR_ONE) : dv_quo[i];
      m = OUT_BITS'(q);
      if (dv_side.zero) begin
        dir_nxt[i] = '0;
      end else begin
        dir_nxt[i] = dv_side.neg[i] ? OUT_BITS'(-m) : m;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && dv_vld) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && dv_vld) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        dir_r[i] <= dir_nxt[i];
      end
      deg_r <= dv_side.zero;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_dir_x      = dir_r[0];
  assign out_dir_y      = dir_r[1];
  assign out_dir_z      = dir_r[2];
  assign out_degenerate = deg_r;

endmodule

/* rtl/crdg_checker.sv */
// Port-level checks for the camera ray direction generator, bound to the top.
// Depends on crdg_pkg and camera_ray_direction_generator_assert.svh.
`include "camera_ray_direction_generator_assert.svh"

module crdg_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [crdg_pkg::OUT_BITS-1:0] out_dir_x,
  input logic signed [crdg_pkg::OUT_BITS-1:0] out_dir_y,
  input logic signed [crdg_pkg::OUT_BITS-1:0] out_dir_z,
  input logic                                 out_degenerate
);
  import crdg_pkg::*;

  // A waiting item stays put
  `CRDG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_dir_x) && $stable(out_dir_y) && $stable(out_dir_z) && $stable(out_degenerate), "result changed while stalled")

  // Input backs up only behind a stalled full output
  `CRDG_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output backpressure")

  // Zero vector gives zero direction
  `CRDG_ASSERT_NOW(a_degen_zero, out_valid && out_degenerate, out_dir_x == 0 && out_dir_y == 0 && out_dir_z == 0, "degenerate item with nonzero direction")

  // Unit components stay within plus or minus one
  `CRDG_ASSERT_NOW(a_dir_range, out_valid, out_dir_x <= DIR_ONE && out_dir_x >= -DIR_ONE && out_dir_y <= DIR_ONE && out_dir_y >= -DIR_ONE && out_dir_z <= DIR_ONE && out_dir_z >= -DIR_ONE, "direction component out of range")

  // Nothing leaves right after reset
  `CRDG_ASSERT_RESET(a_reset_empty, !out_valid, "output valid after reset")

endmodule

bind camera_ray_direction_generator crdg_checker u_crdg_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench for camera_ray_direction_generator.
// Depends on crdg_pkg; predicts each unit ray direction and checks it in order.
`timescale 1ns / 100ps

module tb_top;
  import crdg_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam int PIPE_LATENCY = 58;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] dir_x;
    logic signed [OUT_BITS-1:0] dir_y;
    logic signed [OUT_BITS-1:0] dir_z;
    logic                       degenerate;
  } ray_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [PIXEL_COORD_BITS-1:0]   in_pixel_x;
  logic [PIXEL_COORD_BITS-1:0]   in_pixel_y;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [OUT_BITS-1:0]    out_dir_x;
  logic signed [OUT_BITS-1:0]    out_dir_y;
  logic signed [OUT_BITS-1:0]    out_dir_z;
  logic                          out_degenerate;
  logic                          cfg_wr_en;
  logic [CFG_IDX_BITS-1:0]       cfg_index;
  logic [REG_BITS-1:0]           cfg_data;

  // Shadow copy of the plane vectors
  logic [REG_BITS-1:0] corner_q, column_q, row_q;
  ray_t rays_pending[$];
  int   errors;
  bit   calm;

  camera_ray_direction_generator DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #15ms;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic longint coord_at(logic [REG_BITS-1:0] r, int axis);
    logic signed [COORD_BITS-1:0] c;
    c = r[axis*COORD_BITS +: COORD_BITS];
    return longint'(c);
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] n);
    bit [63:0] root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic ray_t predict_ray(logic [PIXEL_COORD_BITS-1:0] px,
                                       logic [PIXEL_COORD_BITS-1:0] py);
    ray_t      r;
    longint    v;
    bit [63:0] mag[3];
    bit        neg[3];
    bit [63:0] maxm, s, len, q;
    bit [OUT_BITS-1:0] o[3];
    maxm = 0;
    for (int i = 0; i < 3; i++) begin
      v = coord_at(corner_q, i) + longint'(px) * coord_at(column_q, i)
          - longint'(py) * coord_at(row_q, i);
      neg[i] = v < 0;
      mag[i] = neg[i] ? -v : v;
      if (mag[i] > maxm) maxm = mag[i];
    end
    if (maxm == 0) begin
      r = '0;
      r.degenerate = 1'b1;
      return r;
    end
    while (maxm >= (64'd1 << 21)) begin
      maxm >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (maxm < (64'd1 << 20)) begin
      maxm <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    s   = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = int_sqrt(s << 20);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << (DIR_FRAC_BITS + 10)) + (len >> 1)) / len;
      if (q > DIR_ONE) q = DIR_ONE;
      o[i] = OUT_BITS'(neg[i] ? -q : q);
    end
    r.dir_x = o[0];
    r.dir_y = o[1];
    r.dir_z = o[2];
    r.degenerate = 1'b0;
    return r;
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    ray_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rays_pending.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = rays_pending.pop_front();
        if (out_dir_x != want.dir_x) report_mismatch("dir_x", out_dir_x, want.dir_x);
        if (out_dir_y != want.dir_y) report_mismatch("dir_y", out_dir_y, want.dir_y);
        if (out_dir_z != want.dir_z) report_mismatch("dir_z", out_dir_z, want.dir_z);
        if (out_degenerate != want.degenerate)
          report_mismatch("degenerate", out_degenerate, want.degenerate);
      end
    end
  end

  // Receiver back-pressure in bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic send_pixel(logic [PIXEL_COORD_BITS-1:0] px,
                            logic [PIXEL_COORD_BITS-1:0] py);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    do @(posedge clk); while (in_stall);
    rays_pending.push_back(predict_ray(px, py));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (rays_pending.size() != 0) @(posedge clk);
  endtask

  // One write strobe, then write enable is held low before the task returns, so back-to-back writes never overlap
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [REG_BITS-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    unique case (idx)
      CFG_CORNER: corner_q = val;
      CFG_COLUMN: column_q = val;
      CFG_ROW:    row_q    = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_plane(logic [REG_BITS-1:0] c, logic [REG_BITS-1:0] col,
                           logic [REG_BITS-1:0] row);
    drain();
    write_reg(CFG_CORNER, c);
    write_reg(CFG_COLUMN, col);
    write_reg(CFG_ROW, row);
  endtask

  function automatic logic [REG_BITS-1:0] pack3(int x, int y, int z);
    logic [COORD_BITS-1:0] cx, cy, cz;
    cx = COORD_BITS'(x);
    cy = COORD_BITS'(y);
    cz = COORD_BITS'(z);
    return {cz, cy, cx};
  endfunction

  // Coordinate mix: plane-sized, tiny, zero, extreme or fully random
  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom_range(0, 1) ? -(1 << 20) : (1 << 20) - 1;
      2: return int'($urandom_range(0, 64)) - 32;
      3: return int'($urandom_range(0, 4096)) - 2048;
      default: return int'($urandom_range(0, (1 << 21) - 1)) - (1 << 20);
    endcase
  endfunction

  function automatic logic [REG_BITS-1:0] rand_vec();
    return pack3(rand_coord(), rand_coord(), rand_coord());
  endfunction

  function automatic logic [PIXEL_COORD_BITS-1:0] rand_pixel();
    return PIXEL_COORD_BITS'($urandom);
  endfunction

  // ---------------- tests ----------------
  task automatic test_reset_zero_plane;
    // Registers are zero after reset: every ray is degenerate
    send_pixel(0, 0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'h5A5, 12'hA5A);
  endtask

  task automatic test_directed_extremes;
    // Axis-aligned rays give exactly one unit
    set_plane(pack3(1 << 16, 0, 0), '0, '0);
    send_pixel(0, 0);
    set_plane(pack3(0, -(1 << 20), 0), '0, '0);
    send_pixel(12'hFFF, 0);
    set_plane(pack3(0, 0, (1 << 20) - 1), '0, '0);
    send_pixel(0, 12'hFFF);
    // Full-scale corner plus extreme steps at the pixel extremes
    set_plane(pack3((1 << 20) - 1, -(1 << 20), 3), pack3(-(1 << 20), (1 << 20) - 1, 1),
              pack3((1 << 20) - 1, (1 << 20) - 1, -(1 << 20)));
    send_pixel(0, 0);
    send_pixel(12'hFFF, 0);
    send_pixel(0, 12'hFFF);
    send_pixel(12'hFFF, 12'hFFF);
    // Zero vector reached through cancellation
    set_plane(pack3(-4095, 4095, 0), pack3(1, -1, 0), '0);
    send_pixel(12'hFFF, 12'h123);
    send_pixel(12'h001, 12'h000);
    // Out-of-range register index must be ignored
    drain();
    write_reg(CFG_UNUSED, {REG_BITS{1'b1}});
    send_pixel(12'h800, 12'h7FF);
    // Tiny vectors need large upscaling; near-axis ones round near the cap
    set_plane(pack3(1, 1, 1), '0, pack3(0, 0, -1));
    send_pixel(0, 0);
    send_pixel(0, 7);
    set_plane(pack3(1 << 20, 1, 0), pack3(-1, 0, 0), '0);
    send_pixel(12'h3, 0);
  endtask

  task automatic test_random_planes(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      set_plane(rand_vec(), rand_vec(), rand_vec());
      for (int k = 0; k < per_phase; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_pixel($urandom_range(0, 1) ? 12'hFFF : 12'h000, rand_pixel());
        else
          send_pixel(rand_pixel(), rand_pixel());
      end
    end
  endtask

  task automatic test_pause_until_empty;
    // Sender holds off until the pipe has fully drained
    send_pixel(rand_pixel(), rand_pixel());
    drain();
    repeat (3) send_pixel(rand_pixel(), rand_pixel());
  endtask

  task automatic test_full_rate_tail;
    drain();
    calm = 1'b1;
    test_random_planes(2, 100);
  endtask

  initial begin
    errors = 0;
    calm = 1'b0;
    corner_q = '0;
    column_q = '0;
    row_q = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_pixel_x <= '0;
    in_pixel_y <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_CORNER;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_zero_plane();
    test_directed_extremes();
    test_random_planes(20, 70);
    test_pause_until_empty();
    test_full_rate_tail();

    drain();
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (errors == 0 && rays_pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
